### hw/rtl/clws_pkg.sv
package clws_pkg;

  // digits kept for a decimal number, most significant ones dropped beyond this
  localparam int unsigned NumDigits = 5;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned DigCntW   = $clog2(NumDigits + 1);

  localparam int unsigned ValW      = 16;
  localparam int unsigned BitCntW   = $clog2(ValW);
  localparam int unsigned WaitW     = 11;

  localparam logic [7:0]       AsciiZero = 8'd48;
  localparam logic [WaitW-1:0] WaitFset8 = 11'd50;
  localparam logic [WaitW-1:0] WaitFset4 = 11'd40;
  localparam logic [WaitW-1:0] WaitDctl  = 11'd50;
  localparam logic [WaitW-1:0] WaitClear = 11'd2000;
  localparam logic [WaitW-1:0] WaitNone  = 11'd0;

  localparam int unsigned AddrW = 5;

  typedef enum logic [2:0] {
    REG_FOUR_BIT  = 3'd0,
    REG_FSET      = 3'd1,
    REG_DCTL      = 3'd2,
    REG_CLEAR     = 3'd3,
    REG_ENTRY     = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_CMD  = 2'd0,
    OP_CHAR = 2'd1,
    OP_NUM  = 2'd2,
    OP_INIT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STEP_FSET  = 2'd0,
    STEP_DCTL  = 2'd1,
    STEP_CLEAR = 2'd2,
    STEP_ENTRY = 2'd3
  } init_step_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  typedef struct packed {
    logic [1:0]      op;
    logic [ValW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic             reg_select;
    logic [7:0]       bus_value;
    logic [WaitW-1:0] extra_wait_us;
    logic             last;
  } out_item_t;

endpackage

### hw/rtl/char_lcd_write_sequencer_top.sv
// Character LCD write sequencer. Each input transaction (command byte, data
// character, 16-bit number or init request) turns into a run of output
// transactions, one per enable strobe, the final one flagged by last. A number
// is converted bit-serially to BCD (one value bit per cycle), then leading
// zeros are dropped one digit per cycle, then one transfer leaves per cycle
// while the output is not stalled. A new request is taken while the last
// transfer of the previous one still waits in the output register.
// Registers sit on an APB-style port at byte addresses 4*i: four_bit_mode,
// function_set_cmd, display_ctrl_cmd, clear_cmd, entry_mode_cmd; writes are
// expected only while the block is idle.
module char_lcd_write_sequencer_top
  import clws_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,

  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o,

  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // configuration registers
  logic       four_bit_q;
  logic [7:0] fset_q, dctl_q, clear_q, entry_q;

  // sequencer control
  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [ValW-1:0]     val_q, val_d;
  logic [BcdW-1:0]     bcd_q, bcd_d;
  logic [BitCntW-1:0]  bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0]  dig_cnt_q, dig_cnt_d;
  logic                ovf_q, ovf_d;
  init_step_e          step_q, step_d;
  logic                pre_q, pre_d;
  logic                nib_q, nib_d;

  // output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic            in_accept;
  logic            out_free;
  logic            cfg_write;
  reg_idx_e        cfg_idx;
  logic [BcdW-1:0] bcd_adj;

  // transfer being built this cycle
  logic [7:0]       cur_byte;
  logic [WaitW-1:0] cur_wait;
  logic             cur_rs;
  logic             last_byte;

  assign pready     = 1'b1;
  assign cfg_write  = psel & penable & pwrite;
  assign cfg_idx    = reg_idx_e'(paddr[AddrW-1:2]);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // register read-back
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_FOUR_BIT: prdata = {31'd0, four_bit_q};
      REG_FSET:     prdata = {24'd0, fset_q};
      REG_DCTL:     prdata = {24'd0, dctl_q};
      REG_CLEAR:    prdata = {24'd0, clear_q};
      REG_ENTRY:    prdata = {24'd0, entry_q};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      four_bit_q <= 1'b0;
      fset_q     <= 8'd56;
      dctl_q     <= 8'd12;
      clear_q    <= 8'd1;
      entry_q    <= 8'd6;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_FOUR_BIT: four_bit_q <= pwdata[0];
        REG_FSET:     fset_q     <= pwdata[7:0];
        REG_DCTL:     dctl_q     <= pwdata[7:0];
        REG_CLEAR:    clear_q    <= pwdata[7:0];
        REG_ENTRY:    entry_q    <= pwdata[7:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  // double-dabble correction: every digit of five or more gets three added
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // byte, register select and wait of the current transfer
  always_comb begin
    cur_rs    = 1'b0;
    cur_byte  = val_q[7:0];
    cur_wait  = WaitNone;
    last_byte = 1'b1;
    case (op_q)
      OP_CMD: begin
        cur_rs = 1'b0;
      end
      OP_CHAR: begin
        cur_rs = 1'b1;
      end
      OP_NUM: begin
        cur_rs    = 1'b1;
        cur_byte  = AsciiZero + {4'd0, bcd_q[BcdW-1 -: 4]};
        last_byte = (dig_cnt_q == DigCntW'(1));
      end
      OP_INIT: begin
        cur_rs    = 1'b0;
        last_byte = (step_q == STEP_ENTRY);
        case (step_q)
          STEP_FSET: begin
            cur_byte = fset_q;
            cur_wait = four_bit_q ? WaitFset4 : WaitFset8;
          end
          STEP_DCTL: begin
            cur_byte = dctl_q;
            cur_wait = WaitDctl;
          end
          STEP_CLEAR: begin
            cur_byte = clear_q;
            cur_wait = WaitClear;
          end
          STEP_ENTRY: begin
            cur_byte = entry_q;
            cur_wait = WaitNone;
          end
          default: begin
            cur_byte = entry_q;
            cur_wait = WaitNone;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    bcd_d       = bcd_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    ovf_d       = ovf_q;
    step_d      = step_q;
    pre_d       = pre_q;
    nib_d       = nib_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          op_d      = op_e'(in_data_i.op);
          val_d     = in_data_i.value;
          bcd_d     = '0;
          bit_cnt_d = BitCntW'(ValW - 1);
          dig_cnt_d = DigCntW'(NumDigits);
          ovf_d     = 1'b0;
          step_d    = STEP_FSET;
          pre_d     = (op_e'(in_data_i.op) == OP_INIT) & four_bit_q;
          nib_d     = 1'b0;
          state_d   = (op_e'(in_data_i.op) == OP_NUM) ? ST_CONV : ST_EMIT;
        end
      end

      // one value bit per cycle into the bcd shift register
      ST_CONV: begin
        bcd_d = {bcd_adj[BcdW-2:0], val_q[ValW-1]};
        val_d = {val_q[ValW-2:0], 1'b0};
        // a bit leaving the top digit means the number has too many digits
        ovf_d = ovf_q | bcd_adj[BcdW-1];
        if (bit_cnt_q == '0) begin
          state_d = ST_SKIP;
        end else begin
          bit_cnt_d = bit_cnt_q - BitCntW'(1);
        end
      end

      // drop leading zeros, keeping at least one digit
      ST_SKIP: begin
        if ((bcd_q[BcdW-1 -: 4] == 4'd0) && (dig_cnt_q > DigCntW'(1)) && !ovf_q) begin
          bcd_d     = {bcd_q[BcdW-5:0], 4'd0};
          dig_cnt_d = dig_cnt_q - DigCntW'(1);
        end else begin
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.reg_select   = cur_rs;
          if (pre_q) begin
            // lone function-set nibble that opens a 4-bit init
            out_d.bus_value     = {fset_q[7:4], 4'd0};
            out_d.extra_wait_us = WaitNone;
            out_d.last          = 1'b0;
            pre_d               = 1'b0;
          end else if (four_bit_q && !nib_q) begin
            out_d.bus_value     = {cur_byte[7:4], 4'd0};
            out_d.extra_wait_us = WaitNone;
            out_d.last          = 1'b0;
            nib_d               = 1'b1;
          end else begin
            out_d.bus_value     = four_bit_q ? {cur_byte[3:0], 4'd0} : cur_byte;
            out_d.extra_wait_us = cur_wait;
            out_d.last          = last_byte;
            nib_d               = 1'b0;
            step_d              = init_step_e'(step_q + 2'd1);
            bcd_d               = {bcd_q[BcdW-5:0], 4'd0};
            dig_cnt_d           = dig_cnt_q - DigCntW'(1);
            if (last_byte) begin
              state_d = ST_IDLE;
            end
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pre_q       <= 1'b0;
      nib_q       <= 1'b0;
      ovf_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pre_q       <= pre_d;
      nib_q       <= nib_d;
      ovf_q       <= ovf_d;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    val_q     <= val_d;
    bcd_q     <= bcd_d;
    bit_cnt_q <= bit_cnt_d;
    dig_cnt_q <= dig_cnt_d;
    step_q    <= step_d;
    out_q     <= out_d;
  end

endmodule

### verif/char_lcd_write_sequencer_checker.sv
`timescale 1ns / 100ps

module char_lcd_write_sequencer_checker
  import clws_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  in_item_t         in_data_i,

  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  out_item_t        out_data_i,

  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic             pready_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [31:0]      pwdata_i,

  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output int unsigned      requests_o,
  output int unsigned      transfers_o
);

  localparam int unsigned ReportLimit = 10;

  // shadow copy of the register file
  logic       nibble_mode;
  logic [7:0] fset_cmd;
  logic [7:0] dctl_cmd;
  logic [7:0] clear_word;
  logic [7:0] entry_cmd;

  out_item_t lcd_xfer_q[$];
  out_item_t burst_q[$];

  function automatic void add_transfer(logic rs, logic [7:0] bus,
                                       logic [WaitW-1:0] wait_us);
    out_item_t x;
    x.reg_select    = rs;
    x.bus_value     = bus;
    x.extra_wait_us = wait_us;
    x.last          = 1'b0;
    burst_q.push_back(x);
  endfunction

  function automatic void add_byte(logic rs, logic [7:0] b, logic [WaitW-1:0] wait_us);
    if (nibble_mode) begin
      add_transfer(rs, {b[7:4], 4'h0}, WaitNone);
      add_transfer(rs, {b[3:0], 4'h0}, wait_us);
    end else begin
      add_transfer(rs, b, wait_us);
    end
  endfunction

  function automatic void predict_transfers(in_item_t req);
    logic [3:0]      digit [NumDigits];
    logic [ValW-1:0] rest;
    int              n;
    out_item_t       tail;
    burst_q.delete();
    rest = req.value;
    n    = 0;
    case (op_e'(req.op))
      OP_CMD:  add_byte(1'b0, req.value[7:0], WaitNone);
      OP_CHAR: add_byte(1'b1, req.value[7:0], WaitNone);
      OP_NUM: begin
        if (rest == '0) begin
          digit[0] = 4'd0;
          n = 1;
        end else begin
          // lowest digits only, once the digit limit is reached
          while (rest != '0 && n < NumDigits) begin
            digit[n] = 4'(rest % 10);
            rest     = ValW'(rest / 10);
            n++;
          end
        end
        while (n > 0) begin
          n--;
          add_byte(1'b1, AsciiZero + 8'(digit[n]), WaitNone);
        end
      end
      OP_INIT: begin
        if (nibble_mode) begin
          add_transfer(1'b0, {fset_cmd[7:4], 4'h0}, WaitNone);
          add_byte(1'b0, fset_cmd, WaitFset4);
        end else begin
          add_byte(1'b0, fset_cmd, WaitFset8);
        end
        add_byte(1'b0, dctl_cmd, WaitDctl);
        add_byte(1'b0, clear_word, WaitClear);
        add_byte(1'b0, entry_cmd, WaitNone);
      end
      default: ;
    endcase
    tail = burst_q.pop_back();
    tail.last = 1'b1;
    burst_q.push_back(tail);
    foreach (burst_q[i]) lcd_xfer_q.push_back(burst_q[i]);
  endfunction

  function automatic void check_transfer(out_item_t got);
    out_item_t want;
    if (lcd_xfer_q.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= ReportLimit)
        $display("%0t: unexpected transfer rs=%0d bus=%02h wait=%0d last=%0d", $realtime,
                 got.reg_select, got.bus_value, got.extra_wait_us, got.last);
      return;
    end
    want = lcd_xfer_q.pop_front();
    if (got.reg_select !== want.reg_select || got.bus_value !== want.bus_value ||
        got.extra_wait_us !== want.extra_wait_us || got.last !== want.last) begin
      fail_count_o++;
      if (fail_count_o <= ReportLimit)
        $display("%0t: transfer %0d expected rs=%0d bus=%02h wait=%0d last=%0d",
                 $realtime, transfers_o, want.reg_select, want.bus_value,
                 want.extra_wait_us, want.last,
                 ", got rs=%0d bus=%02h wait=%0d last=%0d",
                 got.reg_select, got.bus_value, got.extra_wait_us, got.last);
    end
    transfers_o++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nibble_mode  = 1'b0;
      fset_cmd     = 8'd56;
      dctl_cmd     = 8'd12;
      clear_word   = 8'd1;
      entry_cmd    = 8'd6;
      lcd_xfer_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      requests_o   = 0;
      transfers_o  = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[AddrW-1:2])
          REG_FOUR_BIT: nibble_mode = pwdata_i[0];
          REG_FSET:     fset_cmd    = pwdata_i[7:0];
          REG_DCTL:     dctl_cmd    = pwdata_i[7:0];
          REG_CLEAR:    clear_word  = pwdata_i[7:0];
          REG_ENTRY:    entry_cmd   = pwdata_i[7:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_transfer(out_data_i);
      if (in_valid_i && !in_stall_i) begin
        predict_transfers(in_data_i);
        requests_o++;
      end
      pending_o = lcd_xfer_q.size();
    end
  end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import clws_pkg::*;

  localparam int unsigned HoldCycles  = 300;     // long receiver hold-off
  localparam int unsigned SettleGap   = 4;       // idle cycles before a register write
  localparam int unsigned TailCycles  = 40;
  localparam int unsigned DrainLimit  = 20000;
  localparam int unsigned PhaseItems  = 70;
  localparam longint      TimeoutNs   = 5_000_000;
  localparam logic [2:0]  RegUnused   = 3'd7;    // no register decodes here

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;

  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  int unsigned      fail_count;
  int unsigned      pending;
  int unsigned      requests;
  int unsigned      transfers;

  // shared knobs between the stimulus thread and the receiver
  bit               quiet = 1'b0;        // no random idling on either side
  int unsigned      hold_requests = 0;   // bumped to ask the receiver for a long hold-off
  int unsigned      settings_applied = 0;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  char_lcd_write_sequencer_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // watches both channels and the register port, predicts every transfer
  char_lcd_write_sequencer_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .requests_o   (requests),
    .transfers_o  (transfers)
  );

  // true with a chance of 21 in a hundred, unless a quiet stretch is running
  function automatic bit idle_roll();
    return !quiet && ($urandom_range(99) < 21);
  endfunction

  // receiver: random stalls, plus a counted hold-off whenever one is requested
  initial begin
    int unsigned hold_left;
    int unsigned holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    forever begin
      @(negedge clk);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_roll();
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_request(op_e op, logic [ValW-1:0] value);
    while (idle_roll()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data.op    <= op;
    in_data.value <= value;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // register writes only go out once every predicted transfer has left
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleGap) @(negedge clk);
  endtask

  // setup cycle then access cycle, written when pready is seen high
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // the port goes idle before the next write
    @(negedge clk);
  endtask

  task automatic apply_setting(logic [31:0] mode, logic [31:0] fset, logic [31:0] dctl,
                               logic [31:0] clr, logic [31:0] entry);
    settle_idle();
    write_reg(REG_FOUR_BIT, mode);
    write_reg(REG_FSET, fset);
    write_reg(REG_DCTL, dctl);
    write_reg(REG_CLEAR, clr);
    write_reg(REG_ENTRY, entry);
    settings_applied++;
  endtask

  // random requests; numbers lean toward digit-count boundaries and small values
  task automatic run_random(int unsigned count, int unsigned hold_at);
    op_e              op;
    logic [ValW-1:0]  value;
    int unsigned      pow;
    for (int unsigned k = 0; k < count; k++) begin
      if (k == hold_at) hold_requests++;
      op    = op_e'($urandom_range(3));
      value = ValW'($urandom);
      if (op == OP_NUM) begin
        case ($urandom_range(3))
          0: value = ValW'($urandom_range(9));
          1: value = ValW'($urandom_range(999));
          2: begin
            pow   = 10 ** $urandom_range(4);
            value = ValW'(pow - $urandom_range(1));
          end
          default: ;
        endcase
      end
      send_request(op, value);
    end
  endtask

  initial begin
    int unsigned leftover;
    int unsigned waited;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset settings: 8-bit bus, default init words
    send_request(OP_INIT, 16'h0000);
    send_request(OP_CMD,  16'h0000);
    send_request(OP_CMD,  16'hFF80);   // upper byte of value ignored
    send_request(OP_CHAR, 16'h00FF);
    send_request(OP_CHAR, 16'hA541);
    send_request(OP_NUM,  16'd0);      // zero shows as a single digit
    send_request(OP_NUM,  16'd7);
    send_request(OP_NUM,  16'd10);
    send_request(OP_NUM,  16'd9999);
    send_request(OP_NUM,  16'd10000);
    send_request(OP_NUM,  16'd65535);
    send_request(OP_NUM,  16'h8000);

    // directed, 4-bit bus: lone function-set nibble at the head of init
    apply_setting(32'd1, 32'h28, 32'h0F, 32'h01, 32'h06);
    send_request(OP_INIT, 16'hFFFF);
    send_request(OP_CMD,  16'h00F0);
    send_request(OP_CHAR, 16'hFF0F);
    send_request(OP_NUM,  16'd0);
    send_request(OP_NUM,  16'd65535);
    send_request(OP_NUM,  16'd12345);

    // 8-bit bus, all init words at zero
    apply_setting(32'd0, 32'h00, 32'h00, 32'h00, 32'h00);
    run_random(PhaseItems, PhaseItems);

    // 4-bit bus, all ones, no idling on either side
    apply_setting(32'd1, 32'hFF, 32'hFF, 32'hFF, 32'hFF);
    quiet = 1'b1;
    run_random(PhaseItems, PhaseItems);
    quiet = 1'b0;

    // 4-bit bus, random words; long receiver hold-off fills the block
    apply_setting(32'd1, $urandom, $urandom, $urandom, $urandom);
    run_random(PhaseItems, 10);

    // over-wide write data keeps only the low bits; unused address is ignored
    apply_setting(32'hFFFF_FFFE, {24'hA5A5A5, 8'($urandom)}, $urandom, $urandom, $urandom);
    write_reg(RegUnused, 32'hFFFF_FFFF);
    run_random(PhaseItems, PhaseItems);

    // back to 4-bit with fresh words
    apply_setting(32'd1, $urandom, $urandom, $urandom, $urandom);
    run_random(PhaseItems, PhaseItems);

    // drain, then give a late or extra transfer time to show up
    in_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < DrainLimit) begin
      @(negedge clk);
      waited++;
    end
    repeat (TailCycles) @(negedge clk);
    leftover = pending;
    if (leftover != 0)
      $display("%0d predicted transfers never arrived", leftover);

    $display("summary: %0d requests (commands, chars, numbers, init) over %0d register settings",
             requests, settings_applied + 1);
    $display("summary: %0d transfers checked, %0d mismatched", transfers, fail_count);
    if (fail_count == 0 && leftover == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TimeoutNs);
    $display("timeout with %0d transfers outstanding", pending);
    $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/clws_pkg.sv
hw/rtl/char_lcd_write_sequencer_top.sv
verif/char_lcd_write_sequencer_checker.sv
verif/tb.sv
